>>> hdl/vcf_genotype_line_parser_assert.svh
// assertion macros shared by the genotype line parser rtl
`ifndef VCF_GENOTYPE_LINE_PARSER_ASSERT_SVH
`define VCF_GENOTYPE_LINE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must never hold while out of reset
`define VGP_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

// same-cycle implication
`define VGP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication
`define VGP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define VGP_ASSERT_NEVER(name, clk, rst_n, expr)
`define VGP_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define VGP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/vgp_pkg.sv
// types, constants and helpers of the genotype line parser
package vgp_pkg;

    localparam logic [7:0]  CH_TAB     = 8'd9;
    localparam logic [7:0]  CH_NL      = 8'd10;
    localparam logic [7:0]  CH_COMMA   = 8'h2c;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [3:0]  CODE_OTHER = 4'hf;
    localparam logic [30:0] POS_MAX    = 31'h7fff_ffff;
    localparam logic [7:0]  ALLELE_MAX = 8'd255;
    localparam int          COL_BITS   = 12;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    localparam logic KIND_MUTATION = 1'b0;
    localparam logic KIND_ZERO_POS = 1'b1;

    typedef enum logic [2:0] {
        PH_CHROM,
        PH_POS,
        PH_ID,
        PH_REF,
        PH_ALT,
        PH_SKIP,
        PH_SAMPLE,
        PH_DROP
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [11:0] sample_index;
        logic [30:0] position;
        logic [63:0] chrom_name;
        logic [3:0]  ref_code;
        logic [3:0]  alt_code;
    } t_record;

    typedef struct packed {
        logic        used;
        logic [11:0] sample;
    } t_map_entry;

    // what the parser hands to the record stage for one text byte
    typedef struct packed {
        logic                valid;
        logic                need_map;
        logic [COL_BITS-1:0] column;
        t_record             rec;
    } t_finish;

    function automatic logic [3:0] base_code(input logic [7:0] c);
        logic [3:0] code;
        unique case (c)
            8'h41, 8'h61: code = 4'd1;
            8'h43, 8'h63: code = 4'd2;
            8'h47, 8'h67: code = 4'd4;
            8'h54, 8'h74: code = 4'd8;
            default:      code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/vgp_if.sv
// valid/ready channel interfaces of the genotype line parser
interface vgp_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  data_byte;
    logic [11:0] map_column;
    logic [11:0] map_sample;
    logic        map_used;

    modport source (output valid, cmd, data_byte, map_column, map_sample, map_used,
                    input ready);
    modport sink   (input valid, cmd, data_byte, map_column, map_sample, map_used,
                    output ready);
endinterface

interface vgp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] sample_index;
    logic [30:0] position;
    logic [63:0] chrom_name;
    logic [3:0]  ref_code;
    logic [3:0]  alt_code;

    modport source (output valid, kind, sample_index, position, chrom_name, ref_code,
                    alt_code, input ready);
    modport sink   (input valid, kind, sample_index, position, chrom_name, ref_code,
                    alt_code, output ready);
endinterface

>>> hdl/vgp_ram.sv
// generic single-write, single-read ram with registered read data
module vgp_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/vgp_field_parser.sv
// per-byte field tracking of one variant line
module vgp_field_parser #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ALTS    = 8,
    parameter int CHROM_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    output vgp_pkg::t_finish o_fin
);

    import vgp_pkg::*;

    localparam int          ALT_IW    = (MAX_ALTS > 1) ? $clog2(MAX_ALTS) : 1;
    localparam logic [16:0] COL_LIMIT = 17'(MAX_COLUMNS);
    localparam logic [3:0]  ALT_LIMIT = 4'(MAX_ALTS);
    localparam logic [7:0]  ALT_MAX8  = 8'(MAX_ALTS);
    localparam logic [3:0]  CHROM_LIM = 4'(CHROM_BYTES);

    t_phase              r_phase,  n_phase;
    logic [63:0]         r_chrom,  n_chrom;
    logic [3:0]          r_chrom_len, n_chrom_len;
    logic [30:0]         r_pos,    n_pos;
    logic [3:0]          r_ref,    n_ref;
    logic [3:0]          r_alt_cnt, n_alt_cnt;
    logic [1:0]          r_skip,   n_skip;
    logic [COL_BITS-1:0] r_col,    n_col;
    logic [7:0]          r_allele, n_allele;
    logic                r_digits_done, n_digits_done;
    logic [3:0]          r_alt_list [MAX_ALTS];

    logic        alt_we;
    logic [3:0]  alt_wcode;
    logic        is_digit;
    logic [3:0]  digit;
    logic [34:0] pos_next;
    logic [11:0] allele_next;
    logic [7:0]  alt_sel;
    logic [3:0]  sel_code;
    logic        col_ok;
    t_finish     fin_sample;

    assign is_digit    = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign digit       = 4'(i_data_byte - CH_ZERO);
    assign pos_next    = ({4'd0, r_pos} << 3) + ({4'd0, r_pos} << 1) + 35'(digit);
    assign allele_next = ({4'd0, r_allele} << 3) + ({4'd0, r_allele} << 1) + 12'(digit);

    // alt selected by the allele index, out of range gives the other code
    assign alt_sel = r_allele - 8'd1;
    always_comb begin
        sel_code = CODE_OTHER;
        if ((r_allele <= {4'd0, r_alt_cnt}) && (r_allele <= ALT_MAX8)) begin
            sel_code = r_alt_list[alt_sel[ALT_IW-1:0]];
        end
    end

    assign col_ok = {5'd0, r_col} < COL_LIMIT;

    always_comb begin
        fin_sample                   = '0;
        fin_sample.valid             = col_ok && (r_allele != 8'd0);
        fin_sample.need_map          = 1'b1;
        fin_sample.column            = r_col;
        fin_sample.rec.kind          = KIND_MUTATION;
        fin_sample.rec.position      = r_pos;
        fin_sample.rec.chrom_name    = r_chrom;
        fin_sample.rec.ref_code      = r_ref;
        fin_sample.rec.alt_code      = sel_code;
    end

    always_comb begin
        n_phase       = r_phase;
        n_chrom       = r_chrom;
        n_chrom_len   = r_chrom_len;
        n_pos         = r_pos;
        n_ref         = r_ref;
        n_alt_cnt     = r_alt_cnt;
        n_skip        = r_skip;
        n_col         = r_col;
        n_allele      = r_allele;
        n_digits_done = r_digits_done;
        alt_we        = 1'b0;
        alt_wcode     = base_code(i_data_byte);
        o_fin         = '0;

        if (i_data_byte == CH_NL) begin
            if (r_phase == PH_SAMPLE) begin
                o_fin = fin_sample;
            end
            // newline starts a fresh line
            n_phase       = PH_CHROM;
            n_chrom       = '0;
            n_chrom_len   = '0;
            n_pos         = '0;
            n_ref         = '0;
            n_alt_cnt     = '0;
            n_skip        = '0;
            n_col         = '0;
            n_allele      = '0;
            n_digits_done = 1'b0;
        end else begin
            unique case (r_phase)
                PH_CHROM: begin
                    if (i_data_byte == CH_TAB) begin
                        n_phase = PH_POS;
                    end else if (r_chrom_len < CHROM_LIM) begin
                        n_chrom     = {r_chrom[55:0], i_data_byte};
                        n_chrom_len = r_chrom_len + 4'd1;
                    end
                end
                PH_POS: begin
                    if (i_data_byte == CH_TAB) begin
                        if (r_pos == '0) begin
                            o_fin.valid          = 1'b1;
                            o_fin.rec.kind       = KIND_ZERO_POS;
                            o_fin.rec.chrom_name = r_chrom;
                            n_phase              = PH_DROP;
                        end else begin
                            n_phase = PH_ID;
                        end
                    end else if (is_digit) begin
                        n_pos = (pos_next > {4'd0, POS_MAX}) ? POS_MAX : pos_next[30:0];
                    end
                end
                PH_ID: begin
                    if (i_data_byte == CH_TAB) begin
                        n_phase = PH_REF;
                    end
                end
                PH_REF: begin
                    if (i_data_byte == CH_TAB) begin
                        if (r_ref == 4'd0) begin
                            n_ref = CODE_OTHER;
                        end
                        n_phase = PH_ALT;
                    end else if (r_ref == 4'd0) begin
                        n_ref = base_code(i_data_byte);
                    end
                end
                PH_ALT: begin
                    if (i_data_byte == CH_TAB) begin
                        n_phase = PH_SKIP;
                    end else if ((i_data_byte != CH_COMMA) && (r_alt_cnt < ALT_LIMIT)) begin
                        alt_we    = 1'b1;
                        n_alt_cnt = r_alt_cnt + 4'd1;
                    end
                end
                PH_SKIP: begin
                    if (i_data_byte == CH_TAB) begin
                        if (r_skip == 2'd3) begin
                            n_phase = PH_SAMPLE;
                        end else begin
                            n_skip = r_skip + 2'd1;
                        end
                    end
                end
                PH_SAMPLE: begin
                    if (i_data_byte == CH_TAB) begin
                        o_fin         = fin_sample;
                        n_col         = r_col + 12'd1;
                        n_allele      = '0;
                        n_digits_done = 1'b0;
                    end else if (!r_digits_done) begin
                        if (is_digit) begin
                            n_allele = (allele_next > {4'd0, ALLELE_MAX}) ? ALLELE_MAX
                                                                          : allele_next[7:0];
                        end else begin
                            if (r_allele == 8'd0) begin
                                n_allele = ALLELE_MAX;
                            end
                            n_digits_done = 1'b1;
                        end
                    end
                end
                PH_DROP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_CHROM;
            r_chrom       <= '0;
            r_chrom_len   <= '0;
            r_pos         <= '0;
            r_ref         <= '0;
            r_alt_cnt     <= '0;
            r_skip        <= '0;
            r_col         <= '0;
            r_allele      <= '0;
            r_digits_done <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_chrom       <= n_chrom;
            r_chrom_len   <= n_chrom_len;
            r_pos         <= n_pos;
            r_ref         <= n_ref;
            r_alt_cnt     <= n_alt_cnt;
            r_skip        <= n_skip;
            r_col         <= n_col;
            r_allele      <= n_allele;
            r_digits_done <= n_digits_done;
        end
    end

    // alt list entries are only read below the count, so no reset
    always_ff @(posedge i_clk) begin
        if (i_accept && alt_we) begin
            r_alt_list[r_alt_cnt[ALT_IW-1:0]] <= alt_wcode;
        end
    end

endmodule

>>> hdl/vcf_genotype_line_parser.sv
// top level of the variant-call genotype line parser
//
//  channel   dir  transaction                          accepted when
//  i_item    in   text byte or column map load         i_item.valid && i_item.ready
//  o_rec     out  mutation or zero-position record     o_rec.valid && o_rec.ready
//
// one transaction per cycle while the map is not swept and o_rec does not stall; a
// record passes the column map ram read and record stage, then the output register
// after reset the column map is swept clear, one entry a cycle, over all
// min(MAX_COLUMNS, 4096) entries, during which i_item.ready stays low
// a stalled o_rec holds the record stage, and outside the sweep i_item.ready drops
// only when that stage is full and cannot move
module vcf_genotype_line_parser #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ALTS    = 8,
    parameter int CHROM_BYTES = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vgp_in_if.sink    i_item,
    vgp_out_if.source o_rec
);

    import vgp_pkg::*;

    `include "vcf_genotype_line_parser_assert.svh"

    // only the first 4096 columns can be addressed by 12-bit column numbers
    localparam int          MAP_DEPTH = (MAX_COLUMNS < 4096) ? MAX_COLUMNS : 4096;
    localparam int          MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam logic [16:0] COL_LIMIT = 17'(MAX_COLUMNS);
    localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_DEPTH - 1);

    // clear sweep of the column map
    logic              r_clearing;
    logic [MAP_AW-1:0] r_clr_addr;

    // record stage: holds the record while its map entry is read
    logic    r_cand_valid;
    logic    r_cand_need_map;
    t_record r_cand;

    // output register
    logic    r_out_valid;
    t_record r_out;

    logic              in_accept;
    logic              text_accept;
    logic              map_accept;
    logic              cand_go;
    logic              cand_emit;
    t_finish           fin;
    t_map_entry        map_rdata;
    t_map_entry        map_wdata;
    logic              ram_we;
    logic              ram_re;
    logic [MAP_AW-1:0] ram_waddr;
    logic [MAP_AW-1:0] ram_raddr;
    logic [12:0]       ram_rdata;
    t_record           out_next;
    logic              err_fields_zero;

    assign in_accept   = i_item.valid && i_item.ready;
    assign text_accept = in_accept && (i_item.cmd == CMD_TEXT);
    assign map_accept  = in_accept && (i_item.cmd == CMD_MAP);

    // record stage moves on when the output register is free or being drained
    assign cand_go      = r_cand_valid && (!r_out_valid || o_rec.ready);
    assign i_item.ready = !r_clearing && (!r_cand_valid || cand_go);

    vgp_field_parser #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ALTS    (MAX_ALTS),
        .CHROM_BYTES (CHROM_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (text_accept),
        .i_data_byte (i_item.data_byte),
        .o_fin       (fin)
    );

    // map port: the sweep writes zeros, loads beyond the column range are dropped
    always_comb begin
        map_wdata.used   = i_item.map_used;
        map_wdata.sample = i_item.map_sample;
        ram_waddr        = i_item.map_column[MAP_AW-1:0];
        ram_we           = map_accept && ({5'd0, i_item.map_column} < COL_LIMIT);
        if (r_clearing) begin
            map_wdata = '0;
            ram_waddr = r_clr_addr;
            ram_we    = 1'b1;
        end
    end

    // column lookup is issued with the byte that ends a sample field
    assign ram_re    = text_accept && fin.valid && fin.need_map;
    assign ram_raddr = fin.column[MAP_AW-1:0];

    vgp_ram #(
        .WIDTH (13),
        .DEPTH (MAP_DEPTH)
    ) u_column_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (map_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign map_rdata = t_map_entry'(ram_rdata);

    // error records need no map entry; sample records need a wanted column
    assign cand_emit = !r_cand_need_map || map_rdata.used;

    // sample records take their index from the map entry
    always_comb begin
        out_next = r_cand;
        if (r_cand_need_map) begin
            out_next.sample_index = map_rdata.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_valid <= 1'b0;
        end else if (text_accept) begin
            r_cand_valid <= fin.valid;
        end else if (cand_go) begin
            r_cand_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_accept) begin
            r_cand_need_map <= fin.need_map;
            r_cand          <= fin.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_rec.ready) begin
            r_out_valid <= cand_go && cand_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cand_go && cand_emit) begin
            r_out <= out_next;
        end
    end

    assign o_rec.valid        = r_out_valid;
    assign o_rec.kind         = r_out.kind;
    assign o_rec.sample_index = r_out.sample_index;
    assign o_rec.position     = r_out.position;
    assign o_rec.chrom_name   = r_out.chrom_name;
    assign o_rec.ref_code     = r_out.ref_code;
    assign o_rec.alt_code     = r_out.alt_code;

    assign err_fields_zero = (r_out.position == '0) && (r_out.ref_code == '0)
                             && (r_out.alt_code == '0);

    // nothing is taken while the map is being swept
    `VGP_ASSERT_NEVER(a_no_accept_clearing, i_clk, i_rst_n, r_clearing && i_item.ready)
    // a lookup never collides with a map write
    `VGP_ASSERT_NEVER(a_no_ram_conflict, i_clk, i_rst_n, ram_we && ram_re)
    // a blocked record stage keeps its record
    `VGP_ASSERT_NEXT(a_cand_held, i_clk, i_rst_n, r_cand_valid && !cand_go, r_cand_valid)
    // zero-position records carry zeros in the sample fields
    `VGP_ASSERT_IMPL(a_err_rec_zero, i_clk, i_rst_n, r_out_valid && r_out.kind, err_fields_zero)
    // sample records only come after the ref field has closed
    `VGP_ASSERT_IMPL(a_rec_ref_set, i_clk, i_rst_n, r_out_valid && !r_out.kind, r_out.ref_code != '0)

endmodule
